// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers; each expects clk and an active-low rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lbe_pkg.sv =====
package lbe_pkg;

  // Field widths
  localparam int FUNC_W     = 2;
  localparam int EST_W      = 27;
  localparam int ID_W       = 32;
  localparam int IN_DATA_W  = 272;
  localparam int OUT_DATA_W = 88;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Serial divider: the largest dividend is 2^32 * 10^6, below 2^52
  localparam int DIV_W     = 52;
  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

  // Output field positions
  localparam int OUT_PUBV_BIT = 27;
  localparam int OUT_PUB_LSB  = 28;
  localparam int OUT_PUB_MSB  = 54;

  // Rate limits and scale factors
  localparam logic [EST_W-1:0] EST_MAX = 27'd67108864;
  localparam logic [EST_W-1:0] EST_MIN = 27'd8192;
  localparam logic [31:0] US_PER_S    = 32'd1000000;
  localparam logic [31:0] MS_PER_S    = 32'd1000;
  localparam logic [31:0] PERCENT     = 32'd100;
  localparam logic [3:0]  RUN_MAX     = 4'd15;

  // Cut to 85 percent as estimate * 17 / 20; the divide by 5 is a reciprocal
  // multiply whose quotient sits at bit 34 of the product
  localparam logic [31:0] CUT_SCALE  = 32'd17;
  localparam logic [31:0] DIV5_RECIP = 32'hCCCC_CCCD;

  // Item kinds
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LAUNCH = 2'd0,
    FUNC_EXPIRY = 2'd1,
    FUNC_ACK    = 2'd2,
    FUNC_REPORT = 2'd3
  } func_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_THR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPIRE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_BYTES   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_DRAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PUB_UP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PUB_DOWN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RTT_RISE    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RTT_REPORTS = 3'd7;

  // Clamp a quotient into the legal rate range
  function automatic logic [EST_W-1:0] clamp_rate(input logic [DIV_W-1:0] q);
    logic [EST_W-1:0] r;
    if (q < DIV_W'(EST_MIN)) begin
      r = EST_MIN;
    end else if (q > DIV_W'(EST_MAX)) begin
      r = EST_MAX;
    end else begin
      r = q[EST_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/link_bandwidth_estimator_unit.sv =====
// Launch and expiry items go from idle through dispatch to done; a round-trip cut runs
// the round-trip, multiply and publish steps. Ack and receive-rate items use a bit-serial
// 52-bit divider for the rate quotient; one shared 32x32 multiplier does the other arithmetic.
// One item is worked on at a time; a new item is taken once the result is registered,
// and a stalled result holds the next item in S_DONE until it is taken.
// rst_n is synchronous, active low: state clears to zero, configuration to its defaults.
`include "assert_macros.svh"

module link_bandwidth_estimator_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input item channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // tdata, low bit up: now_ms[31:0], idle_ms[63:32], ack_train_id[95:64],
  // ack_bytes[127:96], ack_delta_us[159:128], rate_bytes[191:160],
  // rate_interval_ms[223:192], rtt_ms[239:224], pending_bytes[271:240]
  input  logic [lbe_pkg::IN_DATA_W-1:0]      in_tdata,
  // tuser, low bit up: func[1:0]
  input  logic [lbe_pkg::FUNC_W-1:0]         in_tuser,
  // Result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // tdata, low bit up: estimate[26:0], publish_valid[27], publish_value[54:28],
  // probe_launched[55], probe_train_id[87:56]
  output logic [lbe_pkg::OUT_DATA_W-1:0]     out_tdata,
  // Configuration write port
  input  logic                               cfg_we,
  input  logic [lbe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lbe_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import lbe_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_RTT,
    S_MUL_DIV,
    S_CUT_MUL,
    S_CUT_APPLY,
    S_DIV_LOAD,
    S_DIV,
    S_DIV_DONE,
    S_ACK_APPLY,
    S_SAT_MUL1,
    S_SAT_MUL2,
    S_SAT_CMP,
    S_REPORT_APPLY,
    S_PUB_MUL1,
    S_PUB_MUL2,
    S_PUB_CMP,
    S_DONE
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [15:0] idle_thr_r;
  logic [15:0] expire_r;
  logic [23:0] sat_bytes_r;
  logic [15:0] sat_drain_r;
  logic [6:0]  pub_up_r;
  logic [6:0]  pub_down_r;
  logic [15:0] rtt_rise_r;
  logic [3:0]  rtt_reports_r;

  // Estimator state
  logic [EST_W-1:0] estimate_r;
  logic [EST_W-1:0] published_r;
  logic [ID_W-1:0]  train_counter_r;
  logic             train_pending_r;
  logic             train_under_load_r;
  logic [31:0]      train_sent_at_r;
  logic [15:0]      lowest_rtt_r;
  logic [3:0]       high_rtt_run_r;

  // Captured item
  func_t       func_r;
  logic [31:0] now_r;
  logic [31:0] idle_r;
  logic [31:0] ack_id_r;
  logic [31:0] ack_bytes_r;
  logic [31:0] ack_delta_r;
  logic [31:0] rate_bytes_r;
  logic [31:0] rate_int_r;
  logic [15:0] rtt_r;
  logic [31:0] pending_r;

  // Working registers
  logic                 cut_r;
  logic                 sat_r;
  logic [EST_W-1:0]     cand_r;
  logic [EST_W-1:0]     arrival_r;
  logic [63:0]          prod_r;
  logic [41:0]          hold_r;
  logic [31:0]          den_r;
  logic [31:0]          rem_r;
  logic [DIV_W-1:0]     dq_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;

  // Result registers
  logic                  res_pub_r;
  logic                  res_launch_r;
  logic [ID_W-1:0]       res_id_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  // Shared multiplier operands
  logic        mul_en;
  logic [31:0] mul_a;
  logic [31:0] mul_b;

  // Divider step
  logic [32:0] div_trial;
  logic        div_ge;

  // Round-trip tracking
  logic [15:0] low_rtt_nxt;
  logic [3:0]  run_nxt;
  logic        cut_nxt;

  // Report and publish helpers
  logic [EST_W:0]   est_sum;
  logic [EST_W-1:0] est_up;
  logic             cand_ge_pub;
  logic [EST_W-1:0] pub_diff;
  logic             out_load;

  // Views for the checks
  logic             est_legal;
  logic             out_pub_flag;
  logic [EST_W-1:0] out_pub_value;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // Select multiplier operands for the current step
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      S_MUL_DIV: begin
        if (func_r == FUNC_ACK) begin
          mul_a = ack_bytes_r;
          mul_b = US_PER_S;
        end else if (cut_r) begin
          mul_a = 32'(estimate_r);
          mul_b = CUT_SCALE;
        end else begin
          mul_a = rate_bytes_r;
          mul_b = MS_PER_S;
        end
      end
      S_CUT_MUL: begin
        mul_a = 32'(prod_r[31:2]);
        mul_b = DIV5_RECIP;
      end
      S_SAT_MUL1: begin
        mul_a = pending_r;
        mul_b = MS_PER_S;
      end
      S_SAT_MUL2: begin
        mul_a = 32'(sat_drain_r) + 32'd1;
        mul_b = 32'(estimate_r);
      end
      S_PUB_MUL1: begin
        mul_a = 32'(published_r);
        mul_b = cand_ge_pub ? 32'(pub_up_r) : 32'(pub_down_r);
      end
      S_PUB_MUL2: begin
        mul_a = 32'(pub_diff) + 32'd1;
        mul_b = PERCENT;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Restoring divider step: bring in one dividend bit, subtract when it fits
  assign div_trial = {rem_r, dq_r[DIV_W-1]};
  assign div_ge    = div_trial >= {1'b0, den_r};

  // Lowest round trip and run of high reports
  always_comb begin
    low_rtt_nxt = ((lowest_rtt_r == '0) || (rtt_r < lowest_rtt_r)) ? rtt_r : lowest_rtt_r;
    if ((rtt_r - low_rtt_nxt) > rtt_rise_r) begin
      run_nxt = (high_rtt_run_r < RUN_MAX) ? high_rtt_run_r + 4'd1 : high_rtt_run_r;
    end else begin
      run_nxt = '0;
    end
    cut_nxt = run_nxt >= rtt_reports_r;
  end

  assign est_sum     = {1'b0, estimate_r} + {1'b0, arrival_r};
  assign est_up      = estimate_r + ((arrival_r - estimate_r) >> 1);
  assign cand_ge_pub = cand_r >= published_r;
  assign pub_diff    = cand_ge_pub ? cand_r - published_r : published_r - cand_r;

  assign est_legal     = (estimate_r == '0) || ((estimate_r >= EST_MIN) && (estimate_r <= EST_MAX));
  assign out_pub_flag  = out_tdata_r[OUT_PUBV_BIT];
  assign out_pub_value = out_tdata_r[OUT_PUB_MSB:OUT_PUB_LSB];

  // Sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= S_IDLE;
      idle_thr_r         <= 16'd5000;
      expire_r           <= 16'd10000;
      sat_bytes_r        <= 24'd262144;
      sat_drain_r        <= 16'd125;
      pub_up_r           <= 7'd25;
      pub_down_r         <= 7'd10;
      rtt_rise_r         <= 16'd150;
      rtt_reports_r      <= 4'd3;
      estimate_r         <= '0;
      published_r        <= '0;
      train_counter_r    <= '0;
      train_pending_r    <= 1'b0;
      train_under_load_r <= 1'b0;
      train_sent_at_r    <= '0;
      lowest_rtt_r       <= '0;
      high_rtt_run_r     <= '0;
      out_valid_r        <= 1'b0;
    end else begin
      // Take configuration writes, keeping each register's width
      if (cfg_we) begin
        case (cfg_index)
          REG_IDLE_THR:    idle_thr_r    <= cfg_wdata[15:0];
          REG_EXPIRE:      expire_r      <= cfg_wdata[15:0];
          REG_SAT_BYTES:   sat_bytes_r   <= cfg_wdata[23:0];
          REG_SAT_DRAIN:   sat_drain_r   <= cfg_wdata[15:0];
          REG_PUB_UP:      pub_up_r      <= cfg_wdata[6:0];
          REG_PUB_DOWN:    pub_down_r    <= cfg_wdata[6:0];
          REG_RTT_RISE:    rtt_rise_r    <= cfg_wdata[15:0];
          REG_RTT_REPORTS: rtt_reports_r <= cfg_wdata[3:0];
          default: ;
        endcase
      end

      if (mul_en) begin
        prod_r <= mul_a * mul_b;
      end

      // Drop the result once taken
      if (out_tvalid && out_tready && !out_load) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            func_r       <= func_t'(in_tuser);
            now_r        <= in_tdata[31:0];
            idle_r       <= in_tdata[63:32];
            ack_id_r     <= in_tdata[95:64];
            ack_bytes_r  <= in_tdata[127:96];
            ack_delta_r  <= in_tdata[159:128];
            rate_bytes_r <= in_tdata[191:160];
            rate_int_r   <= in_tdata[223:192];
            rtt_r        <= in_tdata[239:224];
            pending_r    <= in_tdata[271:240];
            res_pub_r    <= 1'b0;
            res_launch_r <= 1'b0;
            res_id_r     <= '0;
            cut_r        <= 1'b0;
            sat_r        <= 1'b0;
            state_r      <= S_DISPATCH;
          end
        end

        S_DISPATCH: begin
          case (func_r)
            FUNC_LAUNCH: begin
              if (!train_pending_r && (pending_r <= 32'(sat_bytes_r))) begin
                train_counter_r    <= train_counter_r + 32'd1;
                train_sent_at_r    <= now_r;
                train_pending_r    <= 1'b1;
                train_under_load_r <= idle_r < 32'(idle_thr_r);
                res_launch_r       <= 1'b1;
                res_id_r           <= train_counter_r + 32'd1;
              end
              state_r <= S_DONE;
            end
            FUNC_EXPIRY: begin
              if (train_pending_r && ((now_r - train_sent_at_r) >= 32'(expire_r))) begin
                train_pending_r <= 1'b0;
              end
              state_r <= S_DONE;
            end
            FUNC_ACK: begin
              if (train_pending_r && (ack_id_r == train_counter_r)) begin
                train_pending_r <= 1'b0;
                den_r           <= ack_delta_r;
                if (ack_bytes_r == '0) begin
                  state_r <= S_DONE;
                end else if (ack_delta_r == '0) begin
                  cand_r  <= EST_MAX;
                  state_r <= S_ACK_APPLY;
                end else begin
                  state_r <= S_MUL_DIV;
                end
              end else begin
                state_r <= S_DONE;
              end
            end
            FUNC_REPORT: begin
              den_r <= rate_int_r;
              if ((rate_bytes_r == '0) || (rate_int_r == '0)) begin
                state_r <= S_DONE;
              end else if ((rtt_r != '0) && (estimate_r != '0)) begin
                state_r <= S_RTT;
              end else begin
                state_r <= S_MUL_DIV;
              end
            end
            default: state_r <= S_DONE;
          endcase
        end

        // Track queuing delay; a long enough run turns the report into a cut
        S_RTT: begin
          lowest_rtt_r   <= low_rtt_nxt;
          high_rtt_run_r <= cut_nxt ? 4'd0 : run_nxt;
          cut_r          <= cut_nxt;
          state_r        <= S_MUL_DIV;
        end

        S_MUL_DIV: begin
          state_r <= cut_r ? S_CUT_MUL : S_DIV_LOAD;
        end

        S_CUT_MUL: begin
          state_r <= S_CUT_APPLY;
        end

        // Cut to 85 percent, no lower than the rate floor
        S_CUT_APPLY: begin
          if (prod_r[63:34] < 30'(EST_MIN)) begin
            estimate_r <= EST_MIN;
            cand_r     <= EST_MIN;
          end else begin
            estimate_r <= prod_r[60:34];
            cand_r     <= prod_r[60:34];
          end
          state_r <= S_PUB_MUL1;
        end

        S_DIV_LOAD: begin
          dq_r      <= prod_r[DIV_W-1:0];
          rem_r     <= '0;
          div_cnt_r <= '0;
          state_r   <= S_DIV;
        end

        // Shift one quotient bit in per cycle
        S_DIV: begin
          rem_r     <= div_ge ? 32'(div_trial - {1'b0, den_r}) : div_trial[31:0];
          dq_r      <= {dq_r[DIV_W-2:0], div_ge};
          div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
          if (div_cnt_r == DIV_LAST) begin
            state_r <= S_DIV_DONE;
          end
        end

        S_DIV_DONE: begin
          if (func_r == FUNC_ACK) begin
            cand_r  <= clamp_rate(dq_r);
            state_r <= S_ACK_APPLY;
          end else begin
            arrival_r <= clamp_rate(dq_r);
            if (pending_r > 32'(sat_bytes_r)) begin
              sat_r   <= 1'b1;
              state_r <= S_REPORT_APPLY;
            end else if (estimate_r == '0) begin
              state_r <= S_REPORT_APPLY;
            end else begin
              state_r <= S_SAT_MUL1;
            end
          end
        end

        // Under-load trains may only raise the estimate
        S_ACK_APPLY: begin
          if (!(train_under_load_r && (cand_r <= estimate_r))) begin
            estimate_r <= cand_r;
            state_r    <= S_PUB_MUL1;
          end else begin
            state_r <= S_DONE;
          end
        end

        S_SAT_MUL1: begin
          state_r <= S_SAT_MUL2;
        end

        S_SAT_MUL2: begin
          hold_r  <= prod_r[41:0];
          state_r <= S_SAT_CMP;
        end

        // Drain time exceeds the limit when pending * 1000 >= (drain + 1) * estimate
        S_SAT_CMP: begin
          sat_r   <= {22'd0, hold_r} >= prod_r;
          state_r <= S_REPORT_APPLY;
        end

        S_REPORT_APPLY: begin
          if (estimate_r == '0) begin
            estimate_r <= arrival_r;
            cand_r     <= arrival_r;
            state_r    <= S_PUB_MUL1;
          end else if (sat_r) begin
            estimate_r <= est_sum[EST_W:1];
            cand_r     <= est_sum[EST_W:1];
            state_r    <= S_PUB_MUL1;
          end else if (arrival_r > estimate_r) begin
            estimate_r <= est_up;
            cand_r     <= est_up;
            state_r    <= S_PUB_MUL1;
          end else begin
            state_r <= S_DONE;
          end
        end

        // Publish at once when nothing has been published yet
        S_PUB_MUL1: begin
          if (published_r == '0) begin
            published_r <= cand_r;
            res_pub_r   <= 1'b1;
            state_r     <= S_DONE;
          end else begin
            state_r <= S_PUB_MUL2;
          end
        end

        S_PUB_MUL2: begin
          hold_r  <= prod_r[41:0];
          state_r <= S_PUB_CMP;
        end

        // Change passes when (diff + 1) * 100 > published * percent
        S_PUB_CMP: begin
          if (prod_r > {22'd0, hold_r}) begin
            published_r <= cand_r;
            res_pub_r   <= 1'b1;
          end
          state_r <= S_DONE;
        end

        // Hold until the output register is free
        S_DONE: begin
          if (out_load) begin
            out_tdata_r <= {res_id_r, res_launch_r,
                            res_pub_r ? published_r : {EST_W{1'b0}},
                            res_pub_r, estimate_r};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "item taken while busy")
  `ASSERT_ALWAYS(a_est_range, est_legal, "estimate out of range")
  `ASSERT_IMPLIES(a_div_bound, state_r == S_DIV, div_cnt_r <= DIV_LAST, "divider overran")
  `ASSERT_NEXT(a_pub_match, out_load && res_pub_r, out_pub_value == published_r, "value lost")
  `ASSERT_NEXT(a_pub_flag, out_load, out_tvalid && (out_pub_flag == $past(res_pub_r)), "flag lost")

endmodule

// ===== dv/tb_link_bandwidth_estimator_unit.sv =====
module tb_link_bandwidth_estimator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lbe_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int MAX_REPORTED = 100;
  localparam int LAUNCH_BIT   = 55;
  localparam int ID_LSB       = 56;
  localparam logic [26:0] RATE_CEIL  = 27'd67108864;
  localparam logic [26:0] RATE_FLOOR = 27'd8192;

  // One input item, field by field
  typedef struct {
    func_t       func;
    logic [31:0] now_ms;
    logic [31:0] idle_ms;
    logic [31:0] ack_train_id;
    logic [31:0] ack_bytes;
    logic [31:0] ack_delta_us;
    logic [31:0] rate_bytes;
    logic [31:0] rate_interval_ms;
    logic [15:0] rtt_ms;
    logic [31:0] pending_bytes;
  } probe_item_t;

  // One result item, field by field
  typedef struct {
    logic [26:0] estimate;
    logic        publish_valid;
    logic [26:0] publish_value;
    logic        probe_launched;
    logic [31:0] probe_train_id;
  } estimator_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [FUNC_W-1:0]     in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Settings as the block should hold them
  logic [15:0] idle_thr_ms;
  logic [15:0] expire_ms;
  logic [23:0] sat_bytes;
  logic [15:0] sat_drain_ms;
  logic [6:0]  pub_up_pct;
  logic [6:0]  pub_down_pct;
  logic [15:0] rtt_rise;
  logic [3:0]  rtt_reports;

  // Estimator state as the block should hold it
  logic [26:0] est_bw;
  logic [26:0] pub_bw;
  logic [31:0] trains_issued;
  logic        train_open;
  logic        train_loaded;
  logic [31:0] train_start_ms;
  logic [15:0] rtt_floor;
  logic [3:0]  rtt_run;

  estimator_result_t due_results[$];
  int          fail_count;
  int          cycle_count;
  logic [31:0] clock_ms;
  int          rtt_burst;
  logic        idling_on;
  logic        tx_calm;
  logic        rx_calm;

  always #4 clk = ~clk;

  link_bandwidth_estimator_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Return settings and state to their power-on values
  task automatic reset_estimator();
    idle_thr_ms    = 16'd5000;
    expire_ms      = 16'd10000;
    sat_bytes      = 24'd262144;
    sat_drain_ms   = 16'd125;
    pub_up_pct     = 7'd25;
    pub_down_pct   = 7'd10;
    rtt_rise       = 16'd150;
    rtt_reports    = 4'd3;
    est_bw         = '0;
    pub_bw         = '0;
    trains_issued  = '0;
    train_open     = 1'b0;
    train_loaded   = 1'b0;
    train_start_ms = '0;
    rtt_floor      = '0;
    rtt_run        = '0;
  endtask

  function automatic logic [26:0] limit_rate(input logic [63:0] r);
    if (r < 64'(RATE_FLOOR)) return RATE_FLOOR;
    if (r > 64'(RATE_CEIL)) return RATE_CEIL;
    return r[26:0];
  endfunction

  // Publish if none is published yet, else only when the move from it is large enough
  function automatic logic offer_publish(input logic [26:0] bw);
    logic [63:0] margin;
    if (pub_bw != '0) begin
      if (bw >= pub_bw) begin
        margin = 64'(pub_bw) * 64'(pub_up_pct) / 64'd100;
        if (64'(bw - pub_bw) < margin) return 1'b0;
      end else begin
        margin = 64'(pub_bw) * 64'(pub_down_pct) / 64'd100;
        if (64'(pub_bw - bw) < margin) return 1'b0;
      end
    end
    pub_bw = bw;
    return 1'b1;
  endfunction

  // Advance the estimator by one accepted item and return the result it gives
  function automatic estimator_result_t apply_item(input probe_item_t it);
    estimator_result_t r;
    logic [26:0] bw;
    logic [26:0] arrival;
    logic [63:0] cut;
    logic [27:0] bw_sum;
    logic        cut_done;
    logic        saturated;
    logic        changed;
    r.publish_valid  = 1'b0;
    r.probe_launched = 1'b0;
    r.probe_train_id = '0;
    case (it.func)
      FUNC_LAUNCH: begin
        if (!train_open && it.pending_bytes <= 32'(sat_bytes)) begin
          trains_issued    = trains_issued + 32'd1;
          train_start_ms   = it.now_ms;
          train_open       = 1'b1;
          train_loaded     = it.idle_ms < 32'(idle_thr_ms);
          r.probe_launched = 1'b1;
          r.probe_train_id = trains_issued;
        end
      end
      FUNC_EXPIRY: begin
        if (train_open && (it.now_ms - train_start_ms) >= 32'(expire_ms)) train_open = 1'b0;
      end
      FUNC_ACK: begin
        if (train_open && it.ack_train_id == trains_issued) begin
          train_open = 1'b0;
          if (it.ack_bytes != '0) begin
            if (it.ack_delta_us == '0) begin
              bw = RATE_CEIL;
            end else begin
              bw = limit_rate(64'(it.ack_bytes) * 64'd1000000 / 64'(it.ack_delta_us));
            end
            // a train sent under load may only raise the estimate
            if (!(train_loaded && bw <= est_bw)) begin
              est_bw          = bw;
              r.publish_valid = offer_publish(bw);
            end
          end
        end
      end
      default: begin
        if (it.rate_bytes != '0 && it.rate_interval_ms != '0) begin
          arrival  = limit_rate(64'(it.rate_bytes) * 64'd1000 / 64'(it.rate_interval_ms));
          cut_done = 1'b0;
          // track queuing delay and cut on a sustained run of high round trips
          if (it.rtt_ms != '0 && est_bw != '0) begin
            if (rtt_floor == '0 || it.rtt_ms < rtt_floor) rtt_floor = it.rtt_ms;
            if (32'(it.rtt_ms - rtt_floor) > 32'(rtt_rise)) begin
              if (rtt_run != 4'd15) rtt_run = rtt_run + 4'd1;
            end else begin
              rtt_run = '0;
            end
            if (rtt_run >= rtt_reports) begin
              cut             = 64'(est_bw) * 64'd85 / 64'd100;
              rtt_run         = '0;
              est_bw          = (cut < 64'(RATE_FLOOR)) ? RATE_FLOOR : cut[26:0];
              r.publish_valid = offer_publish(est_bw);
              cut_done        = 1'b1;
            end
          end
          // otherwise seed from the arrival rate, or move halfway towards it
          if (!cut_done) begin
            saturated = (it.pending_bytes > 32'(sat_bytes)) ||
                        (est_bw != '0 &&
                         64'(it.pending_bytes) * 64'd1000 / 64'(est_bw) > 64'(sat_drain_ms));
            changed = 1'b1;
            if (est_bw == '0) begin
              est_bw = arrival;
            end else if (saturated) begin
              bw_sum = {1'b0, est_bw} + {1'b0, arrival};
              est_bw = bw_sum[27:1];
            end else if (arrival > est_bw) begin
              est_bw = est_bw + (arrival - est_bw) / 27'd2;
            end else begin
              changed = 1'b0;
            end
            if (changed) r.publish_valid = offer_publish(est_bw);
          end
        end
      end
    endcase
    r.estimate      = est_bw;
    r.publish_value = r.publish_valid ? pub_bw : '0;
    return r;
  endfunction

  // Item of the given kind with random content in every field
  function automatic probe_item_t blank_item(input func_t f);
    probe_item_t it;
    it.func             = f;
    it.now_ms           = $urandom();
    it.idle_ms          = $urandom();
    it.ack_train_id     = $urandom();
    it.ack_bytes        = $urandom();
    it.ack_delta_us     = $urandom();
    it.rate_bytes       = $urandom();
    it.rate_interval_ms = $urandom();
    it.rtt_ms           = 16'($urandom());
    it.pending_bytes    = $urandom();
    return it;
  endfunction

  // Build a mostly well-formed item aimed at the estimator's current state
  function automatic probe_item_t compose_item();
    probe_item_t it;
    int unsigned roll;
    logic [15:0] base;
    logic [31:0] wide;
    it = blank_item(func_t'($urandom_range(0, 3)));
    if ($urandom_range(0, 99) < 8) return it;

    // move the wall clock on, now and then by a long jump or a wrap
    case ($urandom_range(0, 19))
      0:       clock_ms = clock_ms + $urandom_range(60000, 200000);
      1:       clock_ms = $urandom();
      default: clock_ms = clock_ms + $urandom_range(0, 3000);
    endcase
    it.now_ms = clock_ms;

    roll = $urandom_range(0, 99);
    it.func = (roll < 25) ? FUNC_LAUNCH : (roll < 35) ? FUNC_EXPIRY :
              (roll < 60) ? FUNC_ACK : FUNC_REPORT;

    case ($urandom_range(0, 9))
      0, 1, 2, 3: it.pending_bytes = $urandom_range(0, 4096);
      4, 5:       it.pending_bytes = '0;
      6, 7:       it.pending_bytes = $urandom_range(0, 2 * int'(sat_bytes) + 1);
      8:          it.pending_bytes = 32'(sat_bytes) + $urandom_range(0, 1);
      default:    it.pending_bytes = $urandom();
    endcase

    case (it.func)
      FUNC_LAUNCH: begin
        if ($urandom_range(0, 1) == 0) it.idle_ms = $urandom_range(0, int'(idle_thr_ms));
      end
      FUNC_EXPIRY: begin
        if (train_open && $urandom_range(0, 1) == 0) begin
          it.now_ms = train_start_ms + 32'(expire_ms) - $urandom_range(0, 1);
        end
      end
      FUNC_ACK: begin
        if (train_open && $urandom_range(0, 99) < 85) begin
          it.ack_train_id = trains_issued;
        end else if ($urandom_range(0, 1) == 0) begin
          it.ack_train_id = trains_issued;
        end
        roll = $urandom_range(0, 99);
        if (roll < 8) it.ack_bytes = '0;
        else if (roll >= 18) it.ack_bytes = $urandom_range(1, 5000000);
        roll = $urandom_range(0, 99);
        if (roll < 8) it.ack_delta_us = '0;
        else if (roll >= 18) it.ack_delta_us = $urandom_range(1, 3000000);
      end
      default: begin
        roll = $urandom_range(0, 99);
        if (roll < 5) it.rate_bytes = '0;
        else if (roll >= 10) it.rate_bytes = $urandom_range(1000, 20000000);
        roll = $urandom_range(0, 99);
        if (roll < 5) it.rate_interval_ms = '0;
        else if (roll >= 10) it.rate_interval_ms = $urandom_range(1, 3000);

        // round trip: a run of high reports, none, noise, a new low or near the floor
        base = (rtt_floor != '0) ? rtt_floor : 16'($urandom_range(10, 100));
        roll = $urandom_range(0, 99);
        if (rtt_burst == 0 && roll < 8) rtt_burst = $urandom_range(1, 17);
        if (rtt_burst > 0) begin
          rtt_burst--;
          wide = 32'(base) + 32'(rtt_rise) + 32'd1 + $urandom_range(0, 40);
        end else if (roll < 18) begin
          wide = '0;
        end else if (roll < 24) begin
          wide = $urandom_range(0, 65535);
        end else if (roll < 30) begin
          wide = $urandom_range(1, int'(base));
        end else begin
          wide = 32'(base) + $urandom_range(0, 20);
        end
        it.rtt_ms = (wide > 32'd65535) ? 16'hFFFF : wide[15:0];
      end
    endcase
    return it;
  endfunction

  // Offer one item and hold it until taken; tvalid stays up for the caller
  task automatic push_item(input probe_item_t it);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= it.func;
    in_tdata  <= {it.pending_bytes, it.rtt_ms, it.rate_interval_ms, it.rate_bytes,
                  it.ack_delta_us, it.ack_bytes, it.ack_train_id, it.idle_ms, it.now_ms};
    do @(posedge clk); while (!in_tready);
    due_results.push_back(apply_item(it));
  endtask

  task automatic hold_input(input int cycles);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Drop tvalid and wait for every awaited result
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_IDLE_THR:    idle_thr_ms  = val[15:0];
      REG_EXPIRE:      expire_ms    = val[15:0];
      REG_SAT_BYTES:   sat_bytes    = val[23:0];
      REG_SAT_DRAIN:   sat_drain_ms = val[15:0];
      REG_PUB_UP:      pub_up_pct   = val[6:0];
      REG_PUB_DOWN:    pub_down_pct = val[6:0];
      REG_RTT_RISE:    rtt_rise     = val[15:0];
      REG_RTT_REPORTS: rtt_reports  = val[3:0];
      default: ;
    endcase
  endtask

  task automatic send_launch(input logic [31:0] now, input logic [31:0] idle,
                             input logic [31:0] pend);
    probe_item_t it;
    it = blank_item(FUNC_LAUNCH);
    it.now_ms        = now;
    it.idle_ms       = idle;
    it.pending_bytes = pend;
    push_item(it);
  endtask

  task automatic send_expiry(input logic [31:0] now);
    probe_item_t it;
    it = blank_item(FUNC_EXPIRY);
    it.now_ms = now;
    push_item(it);
  endtask

  task automatic send_ack(input logic [31:0] id, input logic [31:0] bytes,
                          input logic [31:0] delta);
    probe_item_t it;
    it = blank_item(FUNC_ACK);
    it.ack_train_id = id;
    it.ack_bytes    = bytes;
    it.ack_delta_us = delta;
    push_item(it);
  endtask

  task automatic send_report(input logic [31:0] bytes, input logic [31:0] interval,
                             input logic [15:0] rtt, input logic [31:0] pend);
    probe_item_t it;
    it = blank_item(FUNC_REPORT);
    it.rate_bytes       = bytes;
    it.rate_interval_ms = interval;
    it.rtt_ms           = rtt;
    it.pending_bytes    = pend;
    push_item(it);
  endtask

  // Random items with bursts of idle cycles and calm stretches between them
  task automatic run_traffic(input int count);
    probe_item_t it;
    for (int n = 0; n < count; n++) begin
      if (idling_on && !tx_calm && $urandom_range(0, 3) == 0) hold_input($urandom_range(1, 7));
      if ($urandom_range(0, 30) == 0) tx_calm = !tx_calm;
      it = compose_item();
      push_item(it);
    end
  endtask

  // Blocked and foreign items, expiry across the clock wrap, rate extremes, cuts
  task automatic test_directed_defaults();
    send_report(32'd0, 32'd1000, 16'd40, 32'd0);
    send_report(32'd1000, 32'd0, 16'd40, 32'd0);
    send_ack(32'd0, 32'd1000, 32'd1000);
    send_launch(32'd0, 32'd0, 32'd262145);
    send_launch(32'hFFFF_F000, 32'd0, 32'd262144);
    send_launch(32'd0, 32'd0, 32'd0);
    send_ack(32'd2, 32'd1000, 32'd1000);
    send_expiry(32'h0000_1000);
    send_expiry(32'h0000_1710);
    send_launch(32'd100, 32'hFFFF_FFFF, 32'd0);
    send_ack(32'd2, 32'd0, 32'd1000);
    send_launch(32'd200, 32'd5000, 32'd0);
    send_ack(32'd3, 32'd1, 32'd0);
    send_launch(32'd300, 32'd4999, 32'd0);
    send_ack(32'd4, 32'd1, 32'hFFFF_FFFF);
    send_launch(32'd400, 32'hFFFF_FFFF, 32'd0);
    send_ack(32'd5, 32'hFFFF_FFFF, 32'd1);
    send_launch(32'd500, 32'hFFFF_FFFF, 32'd0);
    send_ack(32'd6, 32'd1000000, 32'd1000000);
    send_report(32'd2000000, 32'd1000, 16'd40, 32'd0);
    repeat (3) send_report(32'd1000, 32'd1000, 16'd300, 32'd0);
    send_report(32'hFFFF_FFFF, 32'd1, 16'd0, 32'hFFFF_FFFF);
    send_report(32'd10000, 32'd1000, 16'hFFFF, 32'd0);
    drain_results();
  endtask

  // All zero: any report with a round trip cuts the estimate, any train expires at once
  task automatic test_extreme_low_settings();
    write_setting(REG_IDLE_THR, '0);
    write_setting(REG_EXPIRE, '0);
    write_setting(REG_SAT_BYTES, '0);
    write_setting(REG_SAT_DRAIN, '0);
    write_setting(REG_PUB_UP, '0);
    write_setting(REG_PUB_DOWN, '0);
    write_setting(REG_RTT_RISE, '0);
    write_setting(REG_RTT_REPORTS, '0);
    run_traffic(170);
    drain_results();
  endtask

  // Every register written all ones, so only its own width is kept
  task automatic test_extreme_high_settings();
    write_setting(REG_IDLE_THR, '1);
    write_setting(REG_EXPIRE, '1);
    write_setting(REG_SAT_BYTES, '1);
    write_setting(REG_SAT_DRAIN, '1);
    write_setting(REG_PUB_UP, '1);
    write_setting(REG_PUB_DOWN, '1);
    write_setting(REG_RTT_RISE, '1);
    write_setting(REG_RTT_REPORTS, '1);
    run_traffic(170);
    drain_results();
  endtask

  task automatic test_random_settings();
    repeat (4) begin
      write_setting(REG_IDLE_THR, ($urandom_range(0, 1) == 0) ?
                    24'($urandom_range(0, 65535)) : 24'($urandom_range(0, 10000)));
      write_setting(REG_EXPIRE, 24'($urandom_range(0, 65535)));
      write_setting(REG_SAT_BYTES, ($urandom_range(0, 1) == 0) ?
                    24'($urandom()) : 24'($urandom_range(0, 100000)));
      write_setting(REG_SAT_DRAIN, ($urandom_range(0, 1) == 0) ?
                    24'($urandom_range(0, 65535)) : 24'($urandom_range(0, 500)));
      write_setting(REG_PUB_UP, 24'($urandom_range(0, 127)));
      write_setting(REG_PUB_DOWN, 24'($urandom_range(0, 127)));
      write_setting(REG_RTT_RISE, ($urandom_range(0, 3) == 0) ?
                    24'($urandom_range(0, 65535)) : 24'($urandom_range(0, 400)));
      write_setting(REG_RTT_REPORTS, 24'($urandom_range(0, 15)));
      run_traffic(130);
      drain_results();
    end
  endtask

  // Back to the power-on settings, both sides at full rate
  task automatic test_quiet_defaults();
    write_setting(REG_IDLE_THR, 24'd5000);
    write_setting(REG_EXPIRE, 24'd10000);
    write_setting(REG_SAT_BYTES, 24'd262144);
    write_setting(REG_SAT_DRAIN, 24'd125);
    write_setting(REG_PUB_UP, 24'd25);
    write_setting(REG_PUB_DOWN, 24'd10);
    write_setting(REG_RTT_RISE, 24'd150);
    write_setting(REG_RTT_REPORTS, 24'd3);
    idling_on = 1'b0;
    run_traffic(200);
    drain_results();
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    fail_count++;
    if (fail_count <= MAX_REPORTED) $error("%s: expected %0d, actual %0d", field, want, got);
  endtask

  // Check each taken result against the oldest awaited one
  always @(posedge clk) begin : check_results
    estimator_result_t want;
    estimator_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.estimate       = out_tdata[EST_W-1:0];
      got.publish_valid  = out_tdata[OUT_PUBV_BIT];
      got.publish_value  = out_tdata[OUT_PUB_MSB:OUT_PUB_LSB];
      got.probe_launched = out_tdata[LAUNCH_BIT];
      got.probe_train_id = out_tdata[ID_LSB +: ID_W];
      if (due_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTED) $error("result item with none awaited");
      end else begin
        want = due_results.pop_front();
        if (got.estimate != want.estimate)
          report_mismatch("estimate", 32'(want.estimate), 32'(got.estimate));
        if (got.publish_valid != want.publish_valid)
          report_mismatch("publish_valid", 32'(want.publish_valid), 32'(got.publish_valid));
        if (got.publish_value != want.publish_value)
          report_mismatch("publish_value", 32'(want.publish_value), 32'(got.publish_value));
        if (got.probe_launched != want.probe_launched)
          report_mismatch("probe_launched", 32'(want.probe_launched),
                          32'(got.probe_launched));
        if (got.probe_train_id != want.probe_train_id)
          report_mismatch("probe_train_id", want.probe_train_id, got.probe_train_id);
      end
    end
  end

  // Stall the result side in bursts, with calm stretches
  initial begin : drive_out_tready
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (idling_on && !rx_calm && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
      if ($urandom_range(0, 40) == 0) rx_calm = !rx_calm;
    end
  end

  // Abandon a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[link_bandwidth_estimator_unit] ERROR");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = FUNC_LAUNCH;
    cfg_we      = 1'b0;
    cfg_index   = REG_IDLE_THR;
    cfg_wdata   = '0;
    fail_count  = 0;
    cycle_count = 0;
    clock_ms    = '0;
    rtt_burst   = 0;
    idling_on   = 1'b1;
    tx_calm     = 1'b0;
    rx_calm     = 1'b0;
    reset_estimator();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_defaults();
    test_extreme_low_settings();
    test_extreme_high_settings();
    test_random_settings();
    test_quiet_defaults();

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("[link_bandwidth_estimator_unit] OK");
    end else begin
      $display("[link_bandwidth_estimator_unit] ERROR");
    end
    $finish;
  end

endmodule
